// ===== design/block_mosaic_average_macros.svh =====
// assertion macros for the block mosaic averager checker
// no dependencies; included by files that hold concurrent assertions
`ifndef BLOCK_MOSAIC_AVERAGE_MACROS_SVH
`define BLOCK_MOSAIC_AVERAGE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BMA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("block mosaic averager check failed");

// next-cycle implication, sampled on clk, off during reset
`define BMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("block mosaic averager check failed");

`endif

// ===== design/bma_pkg.sv =====
// shared types and constants for the block mosaic averager
// no dependencies; imported by every module of the block
`default_nettype none

package bma_pkg;

    // fixed field widths
    localparam int PIX_W      = 8;
    localparam int SUM_W      = 20;
    localparam int ROW_W      = 10;
    localparam int BCOL_W     = 10;
    localparam int CFG_W      = 11;
    localparam int IDX_W      = 2;
    localparam int Y_W        = 10;
    localparam int HEIGHT_MAX = 1024;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - PIX_W - ROW_W - BCOL_W;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // configuration reset values
    localparam logic [CFG_W-1:0] BLOCK_SIZE_RST   = 11'd8;
    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd512;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd512;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // divider produces one quotient bit per step
    localparam int STEP_W = 3;

    // classified pixel, fixed-width part
    typedef struct packed {
        logic             first;
        logic             emit;
        logic             frame_last;
        logic [ROW_W-1:0] block_row;
        logic [PIX_W-1:0] pixel;
    } item_ctl_t;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ACC,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

`default_nettype wire

// ===== design/bma_front.sv =====
// front end: tracks the raster position and classifies each pixel
// depends on bma_pkg
`default_nettype none

module bma_front #(
    parameter int XW    = 10,
    parameter int B1    = 7,
    parameter int CNT_W = 14
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    restart,
    input  wire logic [B1-1:0]           bs,
    input  wire logic [XW-1:0]           w_last,
    input  wire logic [bma_pkg::Y_W-1:0] h_last,
    input  wire logic                    in_valid,
    input  wire logic [bma_pkg::PIX_W-1:0] in_pixel,
    output logic                         accept,
    input  wire logic                    q_ready,
    output bma_pkg::item_ctl_t           item_ctl,
    output logic [XW-1:0]                item_col,
    output logic [CNT_W-1:0]             item_count
);
    import bma_pkg::*;

    logic [XW-1:0]    x_reg, x_next;
    logic [XW-1:0]    col_reg, col_next;
    logic [B1-1:0]    xin_reg, xin_next;
    logic [Y_W-1:0]   y_reg, y_next;
    logic [B1-1:0]    rib_reg, rib_next;
    logic [ROW_W-1:0] brow_reg, brow_next;
    logic             last_x;
    logic             last_y;
    logic             col_end;
    logic             band_end;
    logic [B1-1:0]    bs_m1;
    logic [B1-1:0]    xin_p1;
    logic [B1-1:0]    rib_p1;

    // position classification
    always_comb
    begin
        bs_m1    = bs - B1'(1);
        last_x   = (x_reg == w_last);
        last_y   = (y_reg == h_last);
        col_end  = (xin_reg == bs_m1) || last_x;
        band_end = (rib_reg == bs_m1) || last_y;
        xin_p1   = xin_reg + B1'(1);
        rib_p1   = rib_reg + B1'(1);
        accept   = in_valid && q_ready;
    end

    // item handed to the queue
    always_comb
    begin
        item_ctl.first      = (xin_reg == '0) && (rib_reg == '0);
        item_ctl.emit       = col_end && band_end;
        item_ctl.frame_last = last_x && last_y;
        item_ctl.block_row  = brow_reg;
        item_ctl.pixel      = in_pixel;
        item_col            = col_reg;
        // block width is the pixels seen in this row, height the rows seen in the band
        item_count          = CNT_W'(xin_p1) * CNT_W'(rib_p1);
    end

    // raster counters advance on every transaction
    always_comb
    begin
        x_next    = x_reg;
        col_next  = col_reg;
        xin_next  = xin_reg;
        y_next    = y_reg;
        rib_next  = rib_reg;
        brow_next = brow_reg;
        if (restart)
        begin
            x_next    = '0;
            col_next  = '0;
            xin_next  = '0;
            y_next    = '0;
            rib_next  = '0;
            brow_next = '0;
        end
        else if (accept)
        begin
            if (last_x)
            begin
                x_next   = '0;
                col_next = '0;
                xin_next = '0;
                if (last_y)
                begin
                    y_next    = '0;
                    rib_next  = '0;
                    brow_next = '0;
                end
                else
                begin
                    y_next = y_reg + Y_W'(1);
                    if (rib_reg == bs_m1)
                    begin
                        rib_next  = '0;
                        brow_next = brow_reg + ROW_W'(1);
                    end
                    else
                    begin
                        rib_next = rib_p1;
                    end
                end
            end
            else
            begin
                x_next = x_reg + XW'(1);
                if (xin_reg == bs_m1)
                begin
                    xin_next = '0;
                    col_next = col_reg + XW'(1);
                end
                else
                begin
                    xin_next = xin_p1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            col_reg  <= '0;
            xin_reg  <= '0;
            y_reg    <= '0;
            rib_reg  <= '0;
            brow_reg <= '0;
        end
        else
        begin
            x_reg    <= x_next;
            col_reg  <= col_next;
            xin_reg  <= xin_next;
            y_reg    <= y_next;
            rib_reg  <= rib_next;
            brow_reg <= brow_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bma_queue.sv =====
// short fifo between the front and back ends
// depends on bma_pkg for depth constants
`default_nettype none

module bma_queue #(
    parameter int WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  ready,
    input  wire logic             pop,
    output logic                  valid,
    output logic [WIDTH-1:0]      dout
);
    import bma_pkg::*;

    logic [WIDTH-1:0]  store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;

    // status and head
    always_comb
    begin
        ready = (fill_reg != QCNT_W'(QUEUE_DEPTH));
        valid = (fill_reg != '0);
        dout  = store_reg[rd_ptr_reg];
    end

    // pointer update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ===== design/bma_back.sv =====
// back end: column sum memory, accumulate, mean divider and result register
// depends on bma_pkg
`default_nettype none

module bma_back #(
    parameter int DEPTH = 1024,
    parameter int XW    = 10,
    parameter int CNT_W = 14
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire bma_pkg::item_ctl_t         q_ctl,
    input  wire logic [XW-1:0]              q_col,
    input  wire logic [CNT_W-1:0]           q_count,
    output logic                            q_pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [bma_pkg::PIX_W-1:0]       out_mean,
    output logic [bma_pkg::ROW_W-1:0]       out_row,
    output logic [bma_pkg::BCOL_W-1:0]      out_col,
    output logic                            out_last
);
    import bma_pkg::*;

    back_state_t      state_reg, state_next;
    item_ctl_t        cur_ctl_reg;
    logic [XW-1:0]    cur_col_reg;
    logic [CNT_W-1:0] cur_count_reg;
    logic             fwd_reg;
    logic [SUM_W-1:0] fwd_sum_reg;
    logic [SUM_W-1:0] rd_data_reg;
    logic [SUM_W-1:0] sums_mem [DEPTH];
    logic [CNT_W-1:0] rem_reg;
    logic [PIX_W-1:0] dq_reg;
    logic [STEP_W-1:0] step_reg;

    logic [SUM_W-1:0] base_sum;
    logic [SUM_W-1:0] acc_sum;
    logic             mem_we;
    logic [SUM_W-1:0] mem_wr_data;
    logic [CNT_W:0]   trial;
    logic             trial_ge;
    logic [CNT_W-1:0] rem_step;
    logic             div_done;

    // accumulate datapath, with forwarding for back-to-back hits on one column
    always_comb
    begin
        base_sum = fwd_reg ? fwd_sum_reg : rd_data_reg;
        acc_sum  = cur_ctl_reg.first ? SUM_W'(cur_ctl_reg.pixel)
                                     : base_sum + SUM_W'(cur_ctl_reg.pixel);
    end

    // restoring divider step; quotient fits in one pixel width
    always_comb
    begin
        trial    = {rem_reg, dq_reg[PIX_W-1]};
        trial_ge = (trial >= {1'b0, cur_count_reg});
        rem_step = trial_ge ? CNT_W'(trial - {1'b0, cur_count_reg}) : CNT_W'(trial);
        div_done = (step_reg == STEP_W'(PIX_W - 1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_ACC;
                end
            end
            BK_ACC:
            begin
                if (cur_ctl_reg.emit)
                begin
                    state_next = BK_DIV;
                end
                else if (!q_valid)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_wr_data = acc_sum;
        out_valid   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = q_valid;
            end
            BK_ACC:
            begin
                mem_we = 1'b1;
                q_pop  = q_valid && !cur_ctl_reg.emit;
                if (cur_ctl_reg.emit)
                begin
                    mem_wr_data = '0;
                end
            end
            BK_DIV:
            begin
                q_pop = 1'b0;
            end
            BK_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // current item and forwarding
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_ctl_reg   <= q_ctl;
            cur_col_reg   <= q_col;
            cur_count_reg <= q_count;
            fwd_reg       <= (state_reg == BK_ACC) && (q_col == cur_col_reg);
            fwd_sum_reg   <= acc_sum;
        end
    end

    // column sum memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sums_mem[cur_col_reg] <= mem_wr_data;
        end
        if (q_pop)
        begin
            rd_data_reg <= sums_mem[q_col];
        end
    end

    // divider: upper sum bits start as the partial remainder
    always_ff @(posedge clk)
    begin
        if ((state_reg == BK_ACC) && cur_ctl_reg.emit)
        begin
            rem_reg  <= CNT_W'(acc_sum >> PIX_W);
            dq_reg   <= acc_sum[PIX_W-1:0];
            step_reg <= '0;
        end
        else if (state_reg == BK_DIV)
        begin
            rem_reg  <= rem_step;
            dq_reg   <= {dq_reg[PIX_W-2:0], trial_ge};
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // result fields hold while the result waits
    always_comb
    begin
        out_mean = dq_reg;
        out_row  = cur_ctl_reg.block_row;
        out_col  = BCOL_W'(cur_col_reg);
        out_last = cur_ctl_reg.frame_last;
    end

endmodule

`default_nettype wire

// ===== design/block_mosaic_average.sv =====
// Block mosaic averager. Grey pixels enter in raster order on the slave stream; one
// result transaction leaves per finished block with its truncated mean, block row and
// block column, tlast marking the final block of the image. Edge blocks are averaged
// over the pixels present. Pixels are taken one per clock while they only add into
// their block column; a pixel that closes a block holds the back end through
// accumulate, the eight-step divider and result hand-off, plus the wait on m_axis_tready,
// during which a four-entry queue keeps taking pixels. After idle the first pixel
// passes through the idle state for the column memory read. Any configuration write to a
// defined register restarts the frame; write only while idle. No clearing pass is
// needed after reset: the first pixel of every block overwrites its column sum.
// Top level; depends on bma_pkg, bma_front, bma_queue, bma_back
`default_nettype none

module block_mosaic_average #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_BLOCK = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration writes
    input  wire logic                           cfg_wr_en,
    input  wire logic [bma_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [bma_pkg::CFG_W-1:0]      cfg_data,
    // pixel stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [bma_pkg::PIX_W-1:0]      s_axis_tdata,  // [7:0] pixel
    // block result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] block_mean, [17:8] block_row, [27:18] block_col, [31:28] zero
    output logic [bma_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tlast   // frame_last
);
    import bma_pkg::*;

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int B1    = $clog2(MAX_BLOCK + 1);
    localparam int CNT_W = 2 * B1;
    localparam int CTL_W = $bits(item_ctl_t);
    localparam int QW    = CTL_W + XW + CNT_W;

    logic [CFG_W-1:0] block_size_reg, block_size_next;
    logic [CFG_W-1:0] image_width_reg, image_width_next;
    logic [CFG_W-1:0] image_height_reg, image_height_next;
    logic             restart;
    logic [B1-1:0]    bs;
    logic [XW-1:0]    w_last;
    logic [Y_W-1:0]   h_last;

    logic             accept;
    logic             q_ready;
    item_ctl_t        f_ctl;
    logic [XW-1:0]    f_col;
    logic [CNT_W-1:0] f_count;
    logic [QW-1:0]    q_din;
    logic [QW-1:0]    q_dout;
    logic             q_valid;
    logic             q_pop;
    item_ctl_t        b_ctl;
    logic [XW-1:0]    b_col;
    logic [CNT_W-1:0] b_count;
    logic [PIX_W-1:0] res_mean;
    logic [ROW_W-1:0] res_row;
    logic [BCOL_W-1:0] res_col;

    // configuration register decode
    always_comb
    begin
        block_size_next   = block_size_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        restart           = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE:
                begin
                    block_size_next = {4'd0, cfg_data[6:0]};
                    restart         = 1'b1;
                end
                REG_IMAGE_WIDTH:
                begin
                    image_width_next = cfg_data;
                    restart          = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    image_height_next = cfg_data;
                    restart           = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg   <= BLOCK_SIZE_RST;
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else
        begin
            block_size_reg   <= block_size_next;
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // clamp register values to the supported range
    always_comb
    begin
        if (block_size_reg == '0)
        begin
            bs = B1'(1);
        end
        else if ({21'd0, block_size_reg} > MAX_BLOCK)
        begin
            bs = B1'(MAX_BLOCK);
        end
        else
        begin
            bs = B1'(block_size_reg);
        end

        if (image_width_reg == '0)
        begin
            w_last = '0;
        end
        else if ({21'd0, image_width_reg} > MAX_WIDTH)
        begin
            w_last = XW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = XW'(image_width_reg - CFG_W'(1));
        end

        if (image_height_reg == '0)
        begin
            h_last = '0;
        end
        else if ({21'd0, image_height_reg} > HEIGHT_MAX)
        begin
            h_last = Y_W'(HEIGHT_MAX - 1);
        end
        else
        begin
            h_last = Y_W'(image_height_reg - CFG_W'(1));
        end
    end

    bma_front #(
        .XW    (XW),
        .B1    (B1),
        .CNT_W (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .bs         (bs),
        .w_last     (w_last),
        .h_last     (h_last),
        .in_valid   (s_axis_tvalid),
        .in_pixel   (s_axis_tdata),
        .accept     (accept),
        .q_ready    (q_ready),
        .item_ctl   (f_ctl),
        .item_col   (f_col),
        .item_count (f_count)
    );

    // queue entry packing
    always_comb
    begin
        q_din   = {f_ctl, f_col, f_count};
        b_ctl   = item_ctl_t'(q_dout[QW-1 -: CTL_W]);
        b_col   = q_dout[CNT_W +: XW];
        b_count = q_dout[CNT_W-1:0];
    end

    bma_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .din   (q_din),
        .ready (q_ready),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_dout)
    );

    bma_back #(
        .DEPTH (MAX_WIDTH),
        .XW    (XW),
        .CNT_W (CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ctl     (b_ctl),
        .q_col     (b_col),
        .q_count   (b_count),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_mean  (res_mean),
        .out_row   (res_row),
        .out_col   (res_col),
        .out_last  (m_axis_tlast)
    );

    // stream ports
    always_comb
    begin
        s_axis_tready = q_ready;
        m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_col, res_row, res_mean};
    end

endmodule

`default_nettype wire

// ===== design/bma_checker.sv =====
// port-level checks for the block mosaic averager, bound to the top level
// depends on bma_pkg and block_mosaic_average_macros.svh
`default_nettype none

`include "block_mosaic_average_macros.svh"

module bma_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [bma_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                           m_axis_tlast
);
    import bma_pkg::*;

    // a stalled result keeps its payload
    `BMA_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // pad bits above the block column stay zero
    `BMA_ASSERT_NOW(a_pad_zero, m_axis_tvalid,
        m_axis_tdata[OUT_DATA_W-1 -: OUT_PAD_W] == '0)

    // each result transaction is followed by a gap while the next block is formed
    `BMA_ASSERT_NEXT(a_result_gap, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)

endmodule

bind block_mosaic_average bma_checker u_checker (.*);

`default_nettype wire

// ===== dv/block_mosaic_average_tb.sv =====
// self-checking testbench for the block mosaic averager: raster pixel stream in,
// block results checked field by field against an in-bench prediction of each block mean
// depends on bma_pkg and block_mosaic_average from the design folder
module block_mosaic_average_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bma_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_BLOCK     = 64;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PER_PASS = 150;
    localparam int TIMEOUT_NS    = 20_000_000;

    // register index with no register behind it
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    // content of a run of pixels
    typedef enum int {
        PIX_UNIFORM,
        PIX_DARK,
        PIX_BRIGHT,
        PIX_MIXED
    } pixel_style_t;

    // one finished block as it should leave the block
    typedef struct packed {
        logic [PIX_W-1:0]  block_mean;
        logic [ROW_W-1:0]  block_row;
        logic [BCOL_W-1:0] block_col;
        logic              frame_last;
    } block_result_t;

    // idle percentages per pass: sender, receiver
    localparam int SEND_IDLE [3] = '{35, 82, 0};
    localparam int RECV_IDLE [3] = '{82, 35, 0};

    // edge settings, one per pass
    localparam int EDGE_BS [3] = '{127, 1, 0};
    localparam int EDGE_W  [3] = '{65, 2047, 1};
    localparam int EDGE_H  [3] = '{2, 1, 64};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [PIX_W-1:0]      s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // pixels waiting to be sent and block results waiting to arrive
    logic [PIX_W-1:0] pixel_queue [$];
    block_result_t    expected_blocks [$];

    logic s_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   fail_count = 0;
    int   pixels_sent = 0;
    int   blocks_checked = 0;
    int   writes_done = 0;

    // mirror of the block: registers as written, sums and raster position
    logic [6:0]       bs_cfg;
    logic [CFG_W-1:0] width_cfg;
    logic [CFG_W-1:0] height_cfg;
    logic [SUM_W-1:0] col_sum [0:MAX_WIDTH-1];
    int unsigned      x_pos;
    int unsigned      y_pos;
    int unsigned      band_row;

    block_mosaic_average #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_BLOCK(MAX_BLOCK)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #TIMEOUT_NS;
        $display("block_mosaic_average_tb failed");
        $finish;
    end

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int unsigned eff_block();
        return clamp_to(bs_cfg, 1, MAX_BLOCK);
    endfunction

    function automatic int unsigned eff_width();
        return clamp_to(width_cfg, 1, MAX_WIDTH);
    endfunction

    function automatic int unsigned eff_height();
        return clamp_to(height_cfg, 1, HEIGHT_MAX);
    endfunction

    // frame restart: sums and positions back to zero
    function automatic void restart_frame();
        for (int i = 0; i < MAX_WIDTH; i++)
            col_sum[i] = '0;
        x_pos = 0;
        y_pos = 0;
        band_row = 0;
    endfunction

    function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        case (idx)
            REG_BLOCK_SIZE:
            begin
                bs_cfg = value[6:0];
                restart_frame();
            end
            REG_IMAGE_WIDTH:
            begin
                width_cfg = value;
                restart_frame();
            end
            REG_IMAGE_HEIGHT:
            begin
                height_cfg = value;
                restart_frame();
            end
            default: ;
        endcase
    endfunction

    // add one pixel to its block column; returns 1 when it closes a block
    function automatic bit model_pixel(input logic [PIX_W-1:0] pix, output block_result_t res);
        int unsigned bs;
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned start;
        int unsigned bw;
        int unsigned bh;
        int unsigned quotient;
        bit last_x;
        bit last_y;
        bit emit;
        bs = eff_block();
        w = eff_width();
        h = eff_height();
        col = x_pos / bs;
        last_x = (x_pos + 1 >= w);
        last_y = (y_pos + 1 >= h);
        emit = (((x_pos % bs) == bs - 1) || last_x) && ((band_row + 1 >= bs) || last_y);
        col_sum[col] = col_sum[col] + pix;
        res = '0;
        if (emit)
        begin
            // edge blocks count only the pixels present
            start = col * bs;
            bw = (w > start) ? (w - start) : 1;
            if (bw > bs)
                bw = bs;
            bh = band_row + 1;
            if (bh > bs)
                bh = bs;
            quotient = col_sum[col] / (bw * bh);
            res.block_mean = quotient[PIX_W-1:0];
            res.block_row = ROW_W'(y_pos / bs);
            res.block_col = BCOL_W'(col);
            res.frame_last = last_x && last_y;
            col_sum[col] = '0;
        end
        // raster advance with wrap at the end of the frame
        if (last_x)
        begin
            x_pos = 0;
            if (last_y)
            begin
                y_pos = 0;
                band_row = 0;
            end
            else
            begin
                y_pos = y_pos + 1;
                band_row = (band_row + 1 >= bs) ? 0 : band_row + 1;
            end
        end
        else
            x_pos = x_pos + 1;
        return emit;
    endfunction

    // prediction on accepted pixels, checking on accepted results
    always @(posedge clk)
    begin : result_check
        block_result_t exp_r;
        bit emit;
        if (!rst_n)
            s_taken <= 1'b0;
        else
        begin
            s_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                emit = model_pixel(s_axis_tdata, exp_r);
                void'(pixel_queue.pop_front());
                pixels_sent++;
                if (emit)
                    expected_blocks.push_back(exp_r);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("unexpected block result tdata %h tlast %b", m_axis_tdata,
                           m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_blocks.pop_front();
                    blocks_checked++;
                    if (m_axis_tdata[7:0] !== exp_r.block_mean)
                    begin
                        $error("block_mean expected %0d actual %0d", exp_r.block_mean,
                               m_axis_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[17:8] !== exp_r.block_row)
                    begin
                        $error("block_row expected %0d actual %0d", exp_r.block_row,
                               m_axis_tdata[17:8]);
                        fail_count++;
                    end
                    if (m_axis_tdata[27:18] !== exp_r.block_col)
                    begin
                        $error("block_col expected %0d actual %0d", exp_r.block_col,
                               m_axis_tdata[27:18]);
                        fail_count++;
                    end
                    if (m_axis_tdata[31:28] !== 4'd0)
                    begin
                        $error("tdata padding expected 0 actual %0d", m_axis_tdata[31:28]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== exp_r.frame_last)
                    begin
                        $error("frame_last expected %0d actual %0d", exp_r.frame_last,
                               m_axis_tlast);
                        fail_count++;
                    end
                end
            end
        end
    end

    // pixel driver and result back-pressure, both on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
            if (!s_axis_tvalid || s_taken)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pixel_queue[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    function automatic logic [PIX_W-1:0] draw_pixel(pixel_style_t style);
        case (style)
            PIX_DARK:   return 8'd0;
            PIX_BRIGHT: return 8'd255;
            PIX_MIXED:  return ($urandom_range(1, 0) == 1) ? 8'd255
                                                           : PIX_W'($urandom_range(3, 0));
            default:    return PIX_W'($urandom_range(255, 0));
        endcase
    endfunction

    task automatic push_pixels(int n, pixel_style_t style);
        @(posedge clk);
        for (int i = 0; i < n; i++)
            pixel_queue.push_back(draw_pixel(style));
    endtask

    // wait until every pixel is in and every block result is out
    task automatic drain_results(int extra);
        while (pixel_queue.size() != 0 || expected_blocks.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        apply_reg(idx, value);
        writes_done++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_value(logic [IDX_W-1:0] idx);
        int r;
        r = $urandom_range(19, 0);
        case (idx)
            REG_BLOCK_SIZE:
            begin
                if (r < 12)
                    return CFG_W'($urandom_range(4, 1));
                if (r < 16)
                    return CFG_W'($urandom_range(12, 5));
                if (r == 16)
                    return '0;
                if (r == 17)
                    return CFG_W'(MAX_BLOCK);
                return CFG_W'($urandom_range(127, 65));
            end
            REG_IMAGE_WIDTH:
            begin
                if (r < 15)
                    return CFG_W'($urandom_range(20, 1));
                if (r < 18)
                    return CFG_W'($urandom_range(48, 21));
                return (r == 18) ? CFG_W'(0) : CFG_W'(1);
            end
            default:
            begin
                if (r < 15)
                    return CFG_W'($urandom_range(12, 1));
                if (r < 18)
                    return CFG_W'($urandom_range(24, 13));
                return (r == 18) ? CFG_W'(0) : CFG_W'(1);
            end
        endcase
    endfunction

    // one random setting followed by whole and partial frames; returns pixels queued
    task automatic run_random_phase(bit force_all, bit force_pause, output int sent);
        int choice;
        int frame_px;
        int total;
        int split;
        logic [IDX_W-1:0] one_idx;
        pixel_style_t style;
        drain_results(SETTLE_CYCLES);
        choice = force_all ? 9 : $urandom_range(9, 0);
        if (choice == 0)
            write_reg(REG_UNUSED, CFG_W'($urandom_range(2047, 0)));
        else if (choice <= 2)
        begin
            one_idx = IDX_W'($urandom_range(2, 0));
            write_reg(one_idx, pick_value(one_idx));
        end
        else
        begin
            write_reg(REG_BLOCK_SIZE, pick_value(REG_BLOCK_SIZE));
            write_reg(REG_IMAGE_WIDTH, pick_value(REG_IMAGE_WIDTH));
            write_reg(REG_IMAGE_HEIGHT, pick_value(REG_IMAGE_HEIGHT));
        end
        frame_px = eff_width() * eff_height();
        total = frame_px * ((frame_px < 300) ? $urandom_range(3, 1) : 1);
        if ($urandom_range(3, 0) == 0)
            total += $urandom_range(frame_px, 0);
        case ($urandom_range(9, 0))
            0:       style = PIX_DARK;
            1:       style = PIX_BRIGHT;
            2:       style = PIX_MIXED;
            default: style = PIX_UNIFORM;
        endcase
        // mid-frame hold until every block so far has come back
        if ((force_pause || $urandom_range(3, 0) == 0) && total > 1)
        begin
            split = $urandom_range(total - 1, 1);
            push_pixels(split, style);
            drain_results(0);
            push_pixels(total - split, style);
        end
        else
            push_pixels(total, style);
        sent = total;
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [PIX_W-1:0] tiny_frame [9];
        int pass_sent;
        int sent;
        bit first;
        tiny_frame = '{8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd1, 8'd7, 8'd9, 8'd200};
        bs_cfg = BLOCK_SIZE_RST[6:0];
        width_cfg = IMAGE_WIDTH_RST;
        height_cfg = IMAGE_HEIGHT_RST;
        restart_frame();
        send_idle_pct = SEND_IDLE[0];
        recv_idle_pct = RECV_IDLE[0];
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: a few pixels that close no block
        push_pixels(4, PIX_UNIFORM);

        // 3x3 image in 2x2 blocks: full, right edge, bottom edge and corner blocks
        drain_results(SETTLE_CYCLES);
        write_reg(REG_BLOCK_SIZE, 11'd2);
        write_reg(REG_IMAGE_WIDTH, 11'd3);
        write_reg(REG_IMAGE_HEIGHT, 11'd3);
        @(posedge clk);
        foreach (tiny_frame[i])
            pixel_queue.push_back(tiny_frame[i]);
        // wrap into the next frame, then a write to no register keeps the frame going
        push_pixels(2, PIX_UNIFORM);
        drain_results(SETTLE_CYCLES);
        write_reg(REG_UNUSED, 11'h7FF);
        push_pixels(4, PIX_MIXED);

        // zero registers clamp to one: every pixel is a whole frame
        drain_results(SETTLE_CYCLES);
        write_reg(REG_IMAGE_WIDTH, 11'd0);
        write_reg(REG_IMAGE_HEIGHT, 11'd0);
        write_reg(REG_BLOCK_SIZE, 11'd0);
        push_pixels(3, PIX_UNIFORM);
        // oversized block clamps to the largest
        drain_results(SETTLE_CYCLES);
        write_reg(REG_BLOCK_SIZE, 11'd127);
        push_pixels(1, PIX_BRIGHT);

        // three passes, each with its own idling, an edge setting and random phases
        for (int pass = 0; pass < 3; pass++)
        begin
            drain_results(SETTLE_CYCLES);
            send_idle_pct = SEND_IDLE[pass];
            recv_idle_pct = RECV_IDLE[pass];
            write_reg(REG_BLOCK_SIZE, CFG_W'(EDGE_BS[pass]));
            write_reg(REG_IMAGE_WIDTH, CFG_W'(EDGE_W[pass]));
            write_reg(REG_IMAGE_HEIGHT, CFG_W'(EDGE_H[pass]));
            push_pixels(eff_width() * eff_height(), (pass == 0) ? PIX_BRIGHT : PIX_UNIFORM);
            pass_sent = 0;
            first = 1'b1;
            while (pass_sent < RANDOM_PER_PASS)
            begin
                run_random_phase(first, first, sent);
                pass_sent += sent;
                first = 1'b0;
            end
        end

        drain_results(SETTLE_CYCLES);
        $display("run covered %0d pixels, %0d block results and %0d register writes",
                 pixels_sent, blocks_checked, writes_done);
        $display("settings spanned clamped, ignored and restarting writes, edge blocks and wrap");
        if (fail_count == 0)
            $display("block_mosaic_average_tb passed");
        else
            $display("block_mosaic_average_tb failed");
        $finish;
    end

endmodule
